// ----- sv/u8enc_pkg.sv -----
`default_nettype none

package u8enc_pkg;

  // sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // left-aligned work word: the top six bits are always the next payload slice
  localparam int unsigned WordW = 24;
  typedef logic [WordW-1:0] word_t;

  localparam logic [20:0] CpMaxOne   = 21'h00007F;
  localparam logic [20:0] CpMaxTwo   = 21'h0007FF;
  localparam logic [20:0] CpMaxThree = 21'h00FFFF;
  localparam logic [20:0] CpMax      = 21'h10FFFF;
  localparam logic [20:0] SurrLo     = 21'h00D800;
  localparam logic [20:0] SurrHi     = 21'h00DFFF;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] ReplReset = 8'h7F;

endpackage

`default_nettype wire

// ----- sv/utf8_codepoint_encoder_core.sv -----
`default_nettype none

// UTF-8 encoder. Each accepted word carries one code point and yields its UTF-8
// sequence on the output channel, lead byte first, one byte per output word,
// with last_byte_o set on the final byte. Surrogates (0xD800..0xDFFF) and values
// above 0x10FFFF yield a single replacement byte (cfg register, reset 0x7F) with
// encode_error_o set; an end-of-input word yields nothing. The input side takes
// one word, then stays busy until its last byte has been moved into the output
// register. A single six-bit slice unit forms one byte per cycle under the
// sequencer while the output side does not stall. The output register lets the
// next word be taken while the final byte of the previous one is still waiting.
// The replacement register is written with cfg_we_i/cfg_wdata_i and should only
// change while idle.
module utf8_codepoint_encoder_core (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // configuration
  input  wire  logic        cfg_we_i,
  input  wire  logic [7:0]  cfg_wdata_i,
  // input words
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic [20:0] code_point_i,
  input  wire  logic        end_marker_i,
  // output words
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_byte_o,
  output logic              encode_error_o
);

  u8enc_pkg::state_e state_q, state_d;

  // replacement byte register
  logic [7:0] repl_q;

  // pending byte, registered ahead of the output register
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_last_q, pend_last_d;
  logic       pend_err_q, pend_err_d;

  // remaining payload and count of continuation bytes still to form
  u8enc_pkg::word_t word_q, word_d;
  logic [1:0]       cnt_q, cnt_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_err_q, out_err_d;

  // shared slice unit
  u8enc_pkg::word_t unit_word, unit_word_next;
  logic [7:0]       unit_prefix, unit_byte;

  // classification of the incoming code point
  logic             cp_ascii, cp_bad;
  logic [1:0]       tails;
  logic [7:0]       lead;
  u8enc_pkg::word_t word_load;
  logic             accept, slot_free;

  assign cp_ascii = code_point_i <= u8enc_pkg::CpMaxOne;
  assign cp_bad   = ((code_point_i >= u8enc_pkg::SurrLo) &&
                     (code_point_i <= u8enc_pkg::SurrHi)) ||
                    (code_point_i > u8enc_pkg::CpMax);

  // left-align so the lead payload sits in the top slice
  always_comb begin
    priority if (code_point_i <= u8enc_pkg::CpMaxTwo) begin
      tails     = 2'd1;
      lead      = u8enc_pkg::LeadTwo;
      word_load = {code_point_i[11:0], 12'h000};
    end else if (code_point_i <= u8enc_pkg::CpMaxThree) begin
      tails     = 2'd2;
      lead      = u8enc_pkg::LeadThree;
      word_load = {code_point_i[17:0], 6'b000000};
    end else begin
      tails     = 2'd3;
      lead      = u8enc_pkg::LeadFour;
      word_load = {3'b000, code_point_i};
    end
  end

  assign in_ready_o = (state_q == u8enc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // idle: unit forms the lead byte, emit: continuation bytes
  assign unit_word   = (state_q == u8enc_pkg::ST_IDLE) ? word_load : word_q;
  assign unit_prefix = (state_q == u8enc_pkg::ST_IDLE) ? lead : u8enc_pkg::ContMark;

  u8enc_byte_unit u_byte_unit (
    .word_i      (unit_word),
    .prefix_i    (unit_prefix),
    .byte_o      (unit_byte),
    .word_next_o (unit_word_next)
  );

  always_comb begin
    state_d     = state_q;
    pend_byte_d = pend_byte_q;
    pend_last_d = pend_last_q;
    pend_err_d  = pend_err_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      u8enc_pkg::ST_IDLE: begin
        if (accept && !end_marker_i) begin
          state_d = u8enc_pkg::ST_EMIT;
          priority if (cp_ascii) begin
            pend_byte_d = code_point_i[7:0];
            pend_last_d = 1'b1;
            pend_err_d  = 1'b0;
          end else if (cp_bad) begin
            pend_byte_d = repl_q;
            pend_last_d = 1'b1;
            pend_err_d  = 1'b1;
          end else begin
            pend_byte_d = unit_byte;
            pend_last_d = 1'b0;
            pend_err_d  = 1'b0;
            word_d      = unit_word_next;
            cnt_d       = tails;
          end
        end
      end
      u8enc_pkg::ST_EMIT: begin
        if (slot_free) begin
          // hand the pending byte over
          out_valid_d = 1'b1;
          out_byte_d  = pend_byte_q;
          out_last_d  = pend_last_q;
          out_err_d   = pend_err_q;
          if (pend_last_q) begin
            state_d = u8enc_pkg::ST_IDLE;
          end else begin
            // next continuation byte
            pend_byte_d = unit_byte;
            pend_last_d = (cnt_q == 2'd1);
            pend_err_d  = 1'b0;
            word_d      = unit_word_next;
            cnt_d       = cnt_q - 2'd1;
          end
        end
      end
      default: state_d = u8enc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u8enc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      repl_q      <= u8enc_pkg::ReplReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    pend_last_q <= pend_last_d;
    pend_err_q  <= pend_err_d;
    word_q      <= word_d;
    cnt_q       <= cnt_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_byte_o    = out_last_q;
  assign encode_error_o = out_err_q;

endmodule

`default_nettype wire

// ----- sv/u8enc_byte_unit.sv -----
`default_nettype none

// shared byte former: prefix merged with the top six bits, word moved up one slice
module u8enc_byte_unit (
  input  wire  u8enc_pkg::word_t word_i,
  input  wire  logic [7:0]       prefix_i,
  output logic [7:0]             byte_o,
  output u8enc_pkg::word_t       word_next_o
);

  assign byte_o      = prefix_i | {2'b00, word_i[u8enc_pkg::WordW-1 -: 6]};
  assign word_next_o = {word_i[u8enc_pkg::WordW-7:0], 6'b000000};

endmodule

`default_nettype wire

// ----- sv/u8enc_checker.sv -----
`default_nettype none

module u8enc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        end_marker_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_byte_o,
  input wire logic        encode_error_o
);

  // a real code point leaves the input side busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !end_marker_i) |=> !in_ready_o)
    else $error("input taken again right after a code point");

  // a flagged replacement byte is always alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && encode_error_o) |-> last_byte_o)
    else $error("error byte not marked last");

  // bytes before the last are lead or continuation bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_byte_o) |-> out_byte_o[7])
    else $error("non-final byte is plain ascii");

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(last_byte_o)))
    else $error("output word changed while stalled");

endmodule

bind utf8_codepoint_encoder_core u8enc_checker u_u8enc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .end_marker_i   (end_marker_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .last_byte_o    (last_byte_o),
  .encode_error_o (encode_error_o)
);

`default_nettype wire
